[rtl/doubly_linked_list_engine_macros.svh]
// Assertion macros shared by the doubly linked list engine.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH
`define DOUBLY_LINKED_LIST_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DLL_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/dll_pkg.sv]
// Shared constants, codes and control/status types of the linked list engine.
// No dependencies.
`timescale 1ns / 1ps
package dll_pkg;

  localparam int POOL_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CMD_W  = 3;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DEL_POS  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DUMP     = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic              accept;
    logic              track_head;
    logic              step;
    logic              cap_head;
    logic              cap_tail;
    logic              cap_walk;
    logic              rd_free;
    logic              alloc;
    logic              wr_node;
    logic              wr_link;
    logic              unlink;
    logic              free_slot;
    logic              emit;
    logic              emit_item;
    logic [STAT_W-1:0] status;
  } dll_ctl_t;

  typedef struct packed {
    logic is_ins;
    logic is_del;
    logic is_dump;
    logic ins_bad;
    logic full;
    logic ins_first;
    logic ins_last;
    logic list_empty;
    logic del_bad;
    logic at_tgt;
    logic dump_last;
  } dll_sts_t;

endpackage

[rtl/dll_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module dll_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/dll_ctrl.sv]
// Command sequencer of the linked list engine.
// Depends on dll_pkg for the control and status types and the status codes.
`timescale 1ns / 1ps
module dll_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  dll_pkg::dll_sts_t sts,
  output dll_pkg::dll_ctl_t ctl
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_WALK    = 4'd2;
  localparam logic [3:0] S_DUMP    = 4'd3;
  localparam logic [3:0] S_ALLOC   = 4'd4;
  localparam logic [3:0] S_ALLOC2  = 4'd5;
  localparam logic [3:0] S_WNODE   = 4'd6;
  localparam logic [3:0] S_WLINK   = 4'd7;
  localparam logic [3:0] S_UNLINK  = 4'd8;
  localparam logic [3:0] S_RELEASE = 4'd9;
  localparam logic [3:0] S_DONE    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    ctl       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        ctl.track_head = 1'b1;
        if (start) begin
          ctl.accept = 1'b1;
          state_nxt  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_ins) begin
          if (sts.ins_bad) begin
            ctl.emit   = 1'b1;
            ctl.status = dll_pkg::ST_RANGE;
            state_nxt  = S_IDLE;
          end else if (sts.full) begin
            ctl.emit   = 1'b1;
            ctl.status = dll_pkg::ST_FULL;
            state_nxt  = S_IDLE;
          end else if (sts.ins_first) begin
            ctl.cap_head = 1'b1;
            state_nxt    = S_ALLOC;
          end else if (sts.ins_last) begin
            ctl.cap_tail = 1'b1;
            state_nxt    = S_ALLOC;
          end else begin
            state_nxt = S_WALK;
          end
        end else if (sts.is_del) begin
          if (sts.list_empty) begin
            ctl.emit   = 1'b1;
            ctl.status = dll_pkg::ST_EMPTY;
            state_nxt  = S_IDLE;
          end else if (sts.del_bad) begin
            ctl.emit   = 1'b1;
            ctl.status = dll_pkg::ST_RANGE;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_WALK;
          end
        end else if (sts.is_dump) begin
          if (sts.list_empty) begin
            ctl.emit   = 1'b1;
            ctl.status = dll_pkg::ST_EMPTY;
            state_nxt  = S_IDLE;
          end else begin
            state_nxt = S_DUMP;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_WALK: begin
        if (sts.at_tgt) begin
          ctl.cap_walk = 1'b1;
          state_nxt    = sts.is_del ? S_UNLINK : S_ALLOC;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_DUMP: begin
        ctl.emit      = 1'b1;
        ctl.emit_item = 1'b1;
        ctl.status    = dll_pkg::ST_OK;
        if (sts.dump_last) begin
          state_nxt = S_IDLE;
        end else begin
          ctl.step = 1'b1;
        end
      end
      S_ALLOC: begin
        ctl.rd_free = 1'b1;
        state_nxt   = S_ALLOC2;
      end
      S_ALLOC2: begin
        ctl.alloc = 1'b1;
        state_nxt = S_WNODE;
      end
      S_WNODE: begin
        ctl.wr_node = 1'b1;
        state_nxt   = S_WLINK;
      end
      S_WLINK: begin
        ctl.wr_link = 1'b1;
        state_nxt   = S_DONE;
      end
      S_UNLINK: begin
        ctl.unlink = 1'b1;
        state_nxt  = S_RELEASE;
      end
      S_RELEASE: begin
        ctl.free_slot = 1'b1;
        ctl.emit      = 1'b1;
        ctl.status    = dll_pkg::ST_OK;
        state_nxt     = S_IDLE;
      end
      S_DONE: begin
        ctl.emit   = 1'b1;
        ctl.status = dll_pkg::ST_OK;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

[rtl/dll_dp.sv]
// Datapath of the linked list engine: list registers, node memories, free list
// and result registers. Depends on dll_pkg and dll_ram.
`timescale 1ns / 1ps
module dll_dp #(
  parameter int POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = dll_pkg::DATA_WIDTH_DEF,
  localparam int LW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dll_pkg::dll_ctl_t           ctl,
  output dll_pkg::dll_sts_t           sts,
  input  logic [dll_pkg::CMD_W-1:0]   in_command,
  input  logic [dll_pkg::POS_W-1:0]   in_position,
  input  logic [DATA_WIDTH-1:0]       in_value,
  output logic                        out_valid,
  output logic [dll_pkg::STAT_W-1:0]  out_status,
  output logic [DATA_WIDTH-1:0]       out_item_value,
  output logic [LW-1:0]               out_item_position,
  output logic [LW-1:0]               out_list_length,
  output logic                        out_last
);

  localparam int AW = $clog2(POOL_DEPTH);
  localparam int CW = ((LW > dll_pkg::POS_W) ? LW : dll_pkg::POS_W) + 1;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);

  logic [dll_pkg::CMD_W-1:0] cmd_r;
  logic [dll_pkg::POS_W-1:0] pos_r;
  logic [DATA_WIDTH-1:0]     val_r;
  logic [LW-1:0] head_r, tail_r, count_r, free_head_r, fresh_r;
  logic [LW-1:0] cur_r, cur_nxt, k_r, k_nxt;
  logic [LW-1:0] a_r, b_r, n_r;

  logic                      out_valid_r;
  logic [dll_pkg::STAT_W-1:0] out_status_r;
  logic [DATA_WIDTH-1:0]     out_value_r;
  logic [LW-1:0]             out_pos_r, out_len_r;
  logic                      out_last_r;

  logic [DATA_WIDTH-1:0] val_rdata;
  logic [LW-1:0]         nxt_rdata, prv_rdata;
  logic                  nxt_we, prv_we;
  logic [LW-1:0]         nxt_waddr, prv_waddr, nxt_wdata, prv_wdata;
  logic [AW-1:0]         nxt_raddr;

  logic [CW-1:0] cnt_ext, cnt_p1, pos_ext, ins_p, tgt;
  logic          a_null, b_null, free_null;

  assign cnt_ext   = CW'(count_r);
  assign cnt_p1    = cnt_ext + CW'(1);
  assign pos_ext   = CW'(pos_r);
  assign a_null    = (a_r == NULL_LINK);
  assign b_null    = (b_r == NULL_LINK);
  assign free_null = (free_head_r == NULL_LINK);

  always_comb begin
    case (cmd_r)
      dll_pkg::CMD_INS_HEAD: ins_p = CW'(1);
      dll_pkg::CMD_INS_TAIL: ins_p = cnt_p1;
      default:               ins_p = pos_ext;
    endcase
    sts.is_ins     = cmd_r inside {dll_pkg::CMD_INS_HEAD, dll_pkg::CMD_INS_TAIL,
                                   dll_pkg::CMD_INS_POS};
    sts.is_del     = (cmd_r == dll_pkg::CMD_DEL_POS);
    sts.is_dump    = (cmd_r == dll_pkg::CMD_DUMP);
    sts.ins_bad    = (ins_p == '0) || (ins_p > cnt_p1);
    sts.full       = (count_r == NULL_LINK);
    sts.ins_first  = (ins_p == CW'(1));
    sts.ins_last   = (ins_p == cnt_p1);
    sts.list_empty = (count_r == '0);
    sts.del_bad    = (pos_ext == '0) || (pos_ext > cnt_ext);
    tgt            = sts.is_del ? pos_ext : (ins_p - CW'(1));
    sts.at_tgt     = (CW'(k_r) == tgt);
    sts.dump_last  = (k_r == count_r) || (nxt_rdata == NULL_LINK);
  end

  always_comb begin
    if (ctl.track_head) begin
      cur_nxt = head_r;
      k_nxt   = LW'(1);
    end else if (ctl.step) begin
      cur_nxt = nxt_rdata;
      k_nxt   = k_r + LW'(1);
    end else begin
      cur_nxt = cur_r;
      k_nxt   = k_r;
    end
  end

  assign nxt_raddr = ctl.rd_free ? free_head_r[AW-1:0] : cur_nxt[AW-1:0];

  always_comb begin
    nxt_we    = 1'b0;
    nxt_waddr = n_r;
    nxt_wdata = b_r;
    prv_we    = 1'b0;
    prv_waddr = n_r;
    prv_wdata = a_r;
    if (ctl.wr_node) begin
      nxt_we = 1'b1;
      prv_we = 1'b1;
    end else if (ctl.wr_link) begin
      nxt_we    = !a_null;
      nxt_waddr = a_r;
      nxt_wdata = n_r;
      prv_we    = !b_null;
      prv_waddr = b_r;
      prv_wdata = n_r;
    end else if (ctl.unlink) begin
      nxt_we    = !a_null;
      nxt_waddr = a_r;
      nxt_wdata = b_r;
      prv_we    = !b_null;
      prv_waddr = b_r;
      prv_wdata = a_r;
    end else if (ctl.free_slot) begin
      nxt_we    = 1'b1;
      nxt_waddr = n_r;
      nxt_wdata = free_head_r;
    end
  end

  dll_ram #(.WIDTH(DATA_WIDTH), .DEPTH(POOL_DEPTH)) u_val_ram (
    .clk   (clk),
    .we    (ctl.wr_node),
    .waddr (n_r[AW-1:0]),
    .wdata (val_r),
    .raddr (cur_nxt[AW-1:0]),
    .rdata (val_rdata)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_nxt_ram (
    .clk   (clk),
    .we    (nxt_we),
    .waddr (nxt_waddr[AW-1:0]),
    .wdata (nxt_wdata),
    .raddr (nxt_raddr),
    .rdata (nxt_rdata)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(POOL_DEPTH)) u_prv_ram (
    .clk   (clk),
    .we    (prv_we),
    .waddr (prv_waddr[AW-1:0]),
    .wdata (prv_wdata),
    .raddr (cur_nxt[AW-1:0]),
    .rdata (prv_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= NULL_LINK;
      tail_r      <= NULL_LINK;
      count_r     <= '0;
      free_head_r <= NULL_LINK;
      fresh_r     <= '0;
      cur_r       <= NULL_LINK;
      k_r         <= LW'(1);
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      k_r         <= k_nxt;
      out_valid_r <= ctl.emit;
      if (ctl.alloc) begin
        if (free_null) begin
          fresh_r <= fresh_r + LW'(1);
        end else begin
          free_head_r <= nxt_rdata;
        end
      end
      if (ctl.free_slot) begin
        free_head_r <= n_r;
      end
      if (ctl.wr_link) begin
        count_r <= count_r + LW'(1);
        if (a_null) begin
          head_r <= n_r;
        end
        if (b_null) begin
          tail_r <= n_r;
        end
      end
      if (ctl.unlink) begin
        count_r <= count_r - LW'(1);
        if (a_null) begin
          head_r <= b_r;
        end
        if (b_null) begin
          tail_r <= a_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      cmd_r <= in_command;
      pos_r <= in_position;
      val_r <= in_value;
    end
    if (ctl.cap_head) begin
      a_r <= NULL_LINK;
      b_r <= head_r;
    end
    if (ctl.cap_tail) begin
      a_r <= tail_r;
      b_r <= NULL_LINK;
    end
    if (ctl.cap_walk) begin
      b_r <= nxt_rdata;
      if (sts.is_del) begin
        n_r <= cur_r;
        a_r <= prv_rdata;
      end else begin
        a_r <= cur_r;
      end
    end
    if (ctl.alloc) begin
      n_r <= free_null ? fresh_r : free_head_r;
    end
    if (ctl.emit) begin
      out_status_r <= ctl.status;
      out_value_r  <= ctl.emit_item ? val_rdata : '0;
      out_pos_r    <= ctl.emit_item ? k_r : '0;
      out_len_r    <= count_r;
      out_last_r   <= ctl.emit_item ? sts.dump_last : 1'b1;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_item_value    = out_value_r;
  assign out_item_position = out_pos_r;
  assign out_list_length   = out_len_r;
  assign out_last          = out_last_r;

endmodule

[rtl/doubly_linked_list_engine.sv]
// Doubly linked list engine. Each result is registered in the cycle after its deciding
// cycle. An error gives a single result; an ignored command code gives none.
// Inserts allocate a node, write it and link it in; inner inserts and deletes first walk
// to the position. A dump gives one result per element, one result per cycle. A new command
// is taken while busy is low; the receiver cannot stall. The walk follows one link per cycle.
// Synchronous active-low reset empties the list at once; no clearing pass.
`timescale 1ns / 1ps
`include "doubly_linked_list_engine_macros.svh"
module doubly_linked_list_engine #(
  parameter int POOL_DEPTH = dll_pkg::POOL_DEPTH_DEF,
  parameter int DATA_WIDTH = dll_pkg::DATA_WIDTH_DEF,
  localparam int LW = $clog2(POOL_DEPTH + 1)
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [dll_pkg::CMD_W-1:0]         in_command,
  input  logic [dll_pkg::POS_W-1:0]         in_position,
  input  logic signed [DATA_WIDTH-1:0]      in_value,
  output logic                              out_valid,
  output logic [dll_pkg::STAT_W-1:0]        out_status,
  output logic signed [DATA_WIDTH-1:0]      out_item_value,
  output logic [LW-1:0]                     out_item_position,
  output logic [LW-1:0]                     out_list_length,
  output logic                              out_last
);

  dll_pkg::dll_ctl_t ctl;
  dll_pkg::dll_sts_t sts;

  dll_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  dll_dp #(
    .POOL_DEPTH (POOL_DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .sts               (sts),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_item_value    (out_item_value),
    .out_item_position (out_item_position),
    .out_list_length   (out_list_length),
    .out_last          (out_last)
  );

  `DLL_ASSERT_NEXT(a_accept_sets_busy, start && !busy, busy, "busy did not rise after a transfer")
  `DLL_ASSERT_SAME(a_length_bound, out_valid, out_list_length <= LW'(POOL_DEPTH), "length exceeds pool")
  `DLL_ASSERT_SAME(a_error_single, out_valid && (out_status != dll_pkg::ST_OK), out_last && (out_item_position == '0), "error result not final")
  `DLL_ASSERT_SAME(a_dump_pos_bound, out_valid && (out_item_position != '0), out_item_position <= out_list_length, "dump position beyond length")

endmodule
